// File: hw/rtl/vn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants, register codes and types of the 2D value noise block.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W = 32;
  localparam int VAL_W   = 32;  // lattice / octave value, signed Q2.30
  localparam int OUT_W   = 35;
  localparam int AMP_W   = 17;  // unsigned Q1.16, 65536 is 1.0
  localparam int AMP_FRAC = 16;
  localparam int OCT_W   = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b1;

  localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
  localparam logic [AMP_W-1:0] PERSISTENCE_RST = 17'd32768;
  localparam logic [OCT_W-1:0] OCTAVE_COUNT_RST = 4'd4;

  localparam logic [31:0] HASH_ROW  = 32'd57;
  localparam int          HASH_SHL  = 13;
  localparam logic [31:0] HASH_A    = 32'd15731;
  localparam logic [31:0] HASH_B    = 32'd789221;
  localparam logic [31:0] HASH_C    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK = 32'h7fffffff;
  localparam logic [31:0] LAT_ONE   = 32'h40000000;

  // register stages inside one octave lane
  localparam int LANE_ST = 13;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } vn_hs_t;

endpackage
`default_nettype wire

// File: hw/rtl/vn_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_in_if
// Coordinate word channel: valid/ready plus one signed Q16.16 pair.
// ----------------------------------------------------------------------------
interface vn_in_if import vn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vn_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_out_if
// Noise word channel: valid/ready plus one signed Q5.30 sample.
// ----------------------------------------------------------------------------
interface vn_out_if import vn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module vn_ctrl import vn_pkg::*; #(
  parameter int NST = LANE_ST + 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           out_ready,
  input  wire logic           settled,
  output vn_hs_t              hs,
  output logic [NST-1:0]      en,
  output logic [NST-1:0]      valid
);

  always_comb begin
    en[NST-1] = !valid[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign hs.in_ready  = en[0] && settled;
  assign hs.out_valid = valid[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid && hs.in_ready;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vn_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_cfg
// Config registers, octave amplitude chain and settle counter.
// ----------------------------------------------------------------------------
module vn_cfg import vn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [AMP_W-1:0]           weight [MAX_OCTAVES],
  output logic                       settled
);

  localparam int SETTLE   = MAX_OCTAVES + 1;
  localparam int SETTLE_W = $clog2(SETTLE + 1);

  logic [AMP_W-1:0]    persistence;   // held clamped to 1.0
  logic [OCT_W-1:0]    octave_count;  // raw, clamped by the weight mask
  logic [AMP_W-1:0]    amp [MAX_OCTAVES];
  logic [SETTLE_W-1:0] settle_cnt;
  logic [2*AMP_W-1:0]  amp_prod [MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence  <= PERSISTENCE_RST;
      octave_count <= OCTAVE_COUNT_RST;
      settle_cnt   <= SETTLE_W'(SETTLE);
    end else if (cfg_we) begin
      settle_cnt <= SETTLE_W'(SETTLE);
      unique case (cfg_index)
        REG_PERSISTENCE: begin
          persistence <= (cfg_data[AMP_W-1:0] > AMP_ONE) ? AMP_ONE : cfg_data[AMP_W-1:0];
        end
        REG_OCTAVE_COUNT: begin
          octave_count <= cfg_data[OCT_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 1'b1;
    end
  end

  assign settled = (settle_cnt == '0);

  // a(i+1) = floor(a(i) * p / 2^16); one step per register
  always_comb begin
    amp_prod[0] = '0;
    for (int i = 1; i < MAX_OCTAVES; i++) begin
      amp_prod[i] = amp[i-1] * persistence;
    end
  end

  always_ff @(posedge clk) begin
    amp[0] <= AMP_ONE;
    for (int i = 1; i < MAX_OCTAVES; i++) begin
      amp[i] <= amp_prod[i][AMP_FRAC +: AMP_W];
    end
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      weight[i] <= (i < int'(octave_count)) ? amp[i] : '0;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vn_octave.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_octave
// One octave lane: scale, hash 4x4 lattice, smooth, bilinear blend.
// ----------------------------------------------------------------------------
module vn_octave import vn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OCT       = 0
) (
  input  wire logic                       clk,
  input  wire logic [LANE_ST-1:0]         en,
  input  wire logic signed [COORD_W-1:0]  coord_x,
  input  wire logic signed [COORD_W-1:0]  coord_y,
  output logic signed [VAL_W-1:0]         octave_value
);

  localparam int SX_W = COORD_W + OCT + FRAC_BITS;
  localparam int DW   = VAL_W + 1;
  localparam int PW   = DW + FRAC_BITS + 1;
  localparam int SM_W = VAL_W + 4;

  logic signed [SX_W-1:0] sx, sy;
  logic [31:0]            ix, iy;
  logic [FRAC_BITS-1:0]   tx_p [1:8];
  logic [FRAC_BITS-1:0]   ty_p [1:11];

  logic [31:0] yr [4];
  logic [31:0] y57 [4];
  logic [31:0] xc [4];
  logic [31:0] nsum [16];
  logic [31:0] n2 [16], n3 [16], n4 [16];
  logic [31:0] nn3 [16], m4 [16], pr5 [16];
  logic [31:0] h5 [16];
  logic signed [VAL_W-1:0] lv [16];
  logic signed [SM_W-1:0]  sm_sum [4];
  logic signed [VAL_W-1:0] sm [4];
  logic signed [DW-1:0]    d1, d2, d3;
  logic signed [VAL_W-1:0] a1, a2, l1, l2, b1, u1, b2, b3;
  logic signed [PW-1:0]    pm1, pm2, pm3;

  // stage 1: scale by 2^OCT, split floor index and fraction
  assign sx = SX_W'(coord_x) <<< OCT;
  assign sy = SX_W'(coord_y) <<< OCT;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ix       <= sx[FRAC_BITS +: 32];
      iy       <= sy[FRAC_BITS +: 32];
      tx_p[1]  <= sx[FRAC_BITS-1:0];
      ty_p[1]  <= sy[FRAC_BITS-1:0];
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k-1]) tx_p[k] <= tx_p[k-1];
    end
    for (int k = 2; k <= 11; k++) begin
      if (en[k-1]) ty_p[k] <= ty_p[k-1];
    end
  end

  // stage 2: n = x + 57y, n ^= n << 13 over the 4x4 neighborhood
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      yr[r]  = iy + 32'(r - 1);
      y57[r] = yr[r] * HASH_ROW;
      xc[r]  = ix + 32'(r - 1);
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        nsum[r*4+c] = xc[c] + y57[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) begin
      if (en[1]) n2[j] <= (nsum[j] << HASH_SHL) ^ nsum[j];
      if (en[2]) begin
        n3[j]  <= n2[j];
        nn3[j] <= n2[j] * n2[j];
      end
      if (en[3]) begin
        n4[j] <= n3[j];
        m4[j] <= nn3[j] * HASH_A + HASH_B;
      end
      if (en[4]) pr5[j] <= n4[j] * m4[j];
      if (en[5]) lv[j]  <= $signed(LAT_ONE - h5[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      h5[j] = (pr5[j] + HASH_C) & HASH_MASK;
    end
  end

  // stage 7: 3x3 smoothing of the four cell corners (grid row = y)
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 2; a++) begin
        sm_sum[b*2+a] =
            SM_W'(lv[b*4+a]) + SM_W'(lv[b*4+a+2])
          + SM_W'(lv[(b+2)*4+a]) + SM_W'(lv[(b+2)*4+a+2])
          + ((SM_W'(lv[(b+1)*4+a]) + SM_W'(lv[(b+1)*4+a+2])
            + SM_W'(lv[b*4+a+1]) + SM_W'(lv[(b+2)*4+a+1])) <<< 1)
          + (SM_W'(lv[(b+1)*4+a+1]) <<< 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (en[6]) sm[j] <= sm_sum[j][SM_W-1:4];
    end
    // stages 8..10: blend along x
    if (en[7]) begin
      d1 <= DW'(sm[1]) - DW'(sm[0]);
      d2 <= DW'(sm[3]) - DW'(sm[2]);
      a1 <= sm[0];
      a2 <= sm[2];
    end
    if (en[8]) begin
      pm1 <= d1 * $signed({1'b0, tx_p[8]});
      pm2 <= d2 * $signed({1'b0, tx_p[8]});
      b1  <= a1;
      l2  <= a2;
    end
    if (en[9]) begin
      l1 <= b1 + pm1[FRAC_BITS +: VAL_W];
      u1 <= l2 + pm2[FRAC_BITS +: VAL_W];
    end
    // stages 11..13: blend along y (u1 holds the upper row)
    if (en[10]) begin
      d3 <= DW'(u1) - DW'(l1);
      b2 <= l1;
    end
    if (en[11]) begin
      pm3 <= d3 * $signed({1'b0, ty_p[11]});
      b3  <= b2;
    end
    if (en[12]) begin
      octave_value <= b3 + pm3[FRAC_BITS +: VAL_W];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/value_noise_2d_octave_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// value_noise_2d_octave_sum
// Fractal 2D value noise: sum of weighted, smoothed, bilinear octaves.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one word per sample: coord_x, coord_y, signed Q16.16.
//   out_ch returns one word per input word, noise_value, signed Q5.30,
//   in input order, saturated to 35 bits.
//   cfg_we/cfg_index/cfg_data write persistence (index 0, Q1.16, clamped
//   to 1.0) and octave_count (index 1, clamped to MAX_OCTAVES). Write only
//   while the pipe is empty.
// Timing:
//   16 register stages between in_ch and out_ch. Throughput one word per
//   cycle while out_ch is ready and the config has settled: all octaves
//   run as parallel lanes of a 13-stage datapath, then weight, partial sum
//   and final sum/saturate.
//   After reset and after every config write, in_ch.ready stays low while
//   the amplitude chain (one multiply per octave per cycle) settles.
// Stall:
//   Each stage loads when it is empty or the next one moves, so a stalled
//   out_ch holds its word and empty stages keep filling; on a stall in_ch.ready
//   drops only once every stage holds a word, and it is also low until settled.
// ----------------------------------------------------------------------------
module value_noise_2d_octave_sum import vn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  vn_in_if.sink                      in_ch,
  vn_out_if.source                   out_ch
);

  localparam int NST    = LANE_ST + 3;
  localparam int NGRP   = (MAX_OCTAVES + 3) / 4;
  localparam int SUM_W  = OUT_W + 1 + $clog2(MAX_OCTAVES + 1);
  localparam int PROD_W = VAL_W + AMP_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  vn_hs_t              hs;
  logic [NST-1:0]      en;
  logic [NST-1:0]      valid;
  logic                settled;
  logic [AMP_W-1:0]    weight [MAX_OCTAVES];
  logic signed [VAL_W-1:0]  ov [MAX_OCTAVES];
  logic signed [PROD_W-1:0] prod [MAX_OCTAVES];
  logic signed [VAL_W-1:0]  term [MAX_OCTAVES];
  logic signed [SUM_W-1:0]  gsum_next [NGRP];
  logic signed [SUM_W-1:0]  gsum [NGRP];
  logic signed [SUM_W-1:0]  total;
  logic signed [OUT_W-1:0]  noise;

  vn_ctrl #(.NST(NST)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .settled   (settled),
    .hs        (hs),
    .en        (en),
    .valid     (valid)
  );

  vn_cfg #(.MAX_OCTAVES(MAX_OCTAVES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weight    (weight),
    .settled   (settled)
  );

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    vn_octave #(.FRAC_BITS(FRAC_BITS), .OCT(i)) u_oct (
      .clk          (clk),
      .en           (en[LANE_ST-1:0]),
      .coord_x      (in_ch.coord_x),
      .coord_y      (in_ch.coord_y),
      .octave_value (ov[i])
    );
  end

  assign in_ch.ready        = hs.in_ready;
  assign out_ch.valid       = hs.out_valid;
  assign out_ch.noise_value = noise;

  // octave term = floor(value * amp / 2^16); masked octaves carry weight 0
  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      prod[i] = ov[i] * $signed({1'b0, weight[i]});
    end
    for (int g = 0; g < NGRP; g++) begin
      gsum_next[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (4 * g + j < MAX_OCTAVES) begin
          gsum_next[g] = gsum_next[g] + SUM_W'(term[4*g+j]);
        end
      end
    end
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + gsum[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LANE_ST]) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        term[i] <= prod[i][AMP_FRAC +: VAL_W];
      end
    end
    if (en[LANE_ST+1]) begin
      gsum <= gsum_next;
    end
    if (en[LANE_ST+2]) begin
      if (total > SAT_MAX) begin
        noise <= SAT_MAX[OUT_W-1:0];
      end else if (total < SAT_MIN) begin
        noise <= SAT_MIN[OUT_W-1:0];
      end else begin
        noise <= total[OUT_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // a config write always blocks the input for the following cycle
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !(in_ch.valid && in_ch.ready))
    else $error("word accepted right after config write");

  // an output word only appears when the stage before it was full
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(valid[NST-2]))
    else $error("output word without source stage");

  // a full pipe with stalled output must not take a word
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (&valid) && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted into full pipe");

  // the first octave weight stays within 1.0 once settled
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    settled |-> (weight[0] <= AMP_ONE))
    else $error("octave weight above one");
`endif

endmodule
`default_nettype wire
